### rtl/pcdt_pkg.sv
// Package for the physical confirmation unit: wait status codes,
// configuration register indexes, field widths and reset values.
// No dependencies.
package pcdt_pkg;

  localparam int unsigned HoldW    = 16;
  localparam int unsigned TimeoutW = 24;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned CfgIdxW  = 3;

  typedef enum logic [2:0] {
    StIdle        = 3'd0,
    StWaiting     = 3'd1,
    StConfirmed   = 3'd2,
    StTimeout     = 3'd3,
    StNotRequired = 3'd4
  } wait_status_e;

  typedef enum logic [ModeW-1:0] {
    ModeDisabled = 2'd0,
    ModeButton   = 2'd1,
    ModeJumper   = 2'd2,
    ModeEither   = 2'd3
  } confirm_mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgConfirmMode = 3'd0,
    CfgButtonDeb   = 3'd1,
    CfgJumperDeb   = 3'd2,
    CfgPressMin    = 3'd3,
    CfgWaitTimeout = 3'd4
  } cfg_index_e;

  localparam logic [HoldW-1:0]    ButtonDebReset  = 16'd50;
  localparam logic [HoldW-1:0]    JumperDebReset  = 16'd10;
  localparam logic [HoldW-1:0]    PressMinReset   = 16'd100;
  localparam logic [TimeoutW-1:0] TimeoutReset    = 24'd30000;

  typedef struct packed {
    logic raw_button_low;
    logic raw_jumper_low;
    logic start_wait;
    logic password_set;
  } item_t;

endpackage

### rtl/pcdt_debounce.sv
// Single-pin debouncer: hold counter with saturation, stable level follows
// the raw sample once it has been steady for the programmed tick count.
// Depends on pcdt_pkg.
module pcdt_debounce (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      raw_i,
  input  logic [pcdt_pkg::HoldW-1:0] limit_i,
  output logic                      stable_next_o
);
  import pcdt_pkg::*;

  logic             prev_q, prev_d;
  logic             known_q, known_d;
  logic             stable_q, stable_d;
  logic [HoldW-1:0] hold_q, hold_d;

  always_comb begin
    if (!known_q || (raw_i != prev_q)) begin
      hold_d = '0;
    end else if (&hold_q) begin
      hold_d = hold_q;
    end else begin
      hold_d = hold_q + {{(HoldW-1){1'b0}}, 1'b1};
    end
    stable_d = (hold_d >= limit_i) ? raw_i : stable_q;
    prev_d   = raw_i;
    known_d  = 1'b1;
  end

  assign stable_next_o = stable_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= 1'b0;
      known_q  <= 1'b0;
      stable_q <= 1'b0;
      hold_q   <= '0;
    end else if (en_i) begin
      prev_q   <= prev_d;
      known_q  <= known_d;
      stable_q <= stable_d;
      hold_q   <= hold_d;
    end
  end

endmodule

### rtl/physical_confirm_debounce_timeout_unit.sv
// Physical confirmation unit: button/jumper debounce, minimum press hold
// and wait timeout, one millisecond tick per input transfer.
// Depends on pcdt_pkg and pcdt_debounce.
//
//   channel | handshake               | payload
//   --------+-------------------------+------------------------------------
//   tick in | in_valid_i / in_stall_o | raw_button_low, raw_jumper_low,
//           |                         | start_wait, password_set
//   result  | out_valid_o/out_stall_i | button_pressed, jumper_installed,
//           |                         | confirmed_now, wait_status
//   config  | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One tick per cycle sustained while the result is not stalled; each tick passes
// through the input register, then the debounce and wait logic feeding the result register.
// Reset clears all pin and wait state and loads the register defaults.
// A stalled result holds; the input register still takes a tick while the
// result waits, and stalls only when both stages are full.
module physical_confirm_debounce_timeout_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          raw_button_low_i,
  input  logic                          raw_jumper_low_i,
  input  logic                          start_wait_i,
  input  logic                          password_set_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          button_pressed_o,
  output logic                          jumper_installed_o,
  output logic                          confirmed_now_o,
  output logic [2:0]                    wait_status_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pcdt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pcdt_pkg::TimeoutW-1:0] cfg_data_i
);
  import pcdt_pkg::*;

  // configuration
  confirm_mode_e       mode_q;
  logic [HoldW-1:0]    button_deb_q, jumper_deb_q, press_min_q;
  logic [TimeoutW-1:0] timeout_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= ModeEither;
      button_deb_q <= ButtonDebReset;
      jumper_deb_q <= JumperDebReset;
      press_min_q  <= PressMinReset;
      timeout_q    <= TimeoutReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_e'(cfg_index_i))
        CfgConfirmMode: mode_q       <= confirm_mode_e'(cfg_data_i[ModeW-1:0]);
        CfgButtonDeb:   button_deb_q <= cfg_data_i[HoldW-1:0];
        CfgJumperDeb:   jumper_deb_q <= cfg_data_i[HoldW-1:0];
        CfgPressMin:    press_min_q  <= cfg_data_i[HoldW-1:0];
        CfgWaitTimeout: timeout_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input stage
  logic  in_valid_q;
  item_t item_q;
  logic  out_free;
  logic  advance;

  assign out_free   = !out_valid_o || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      item_q <= '{raw_button_low: raw_button_low_i, raw_jumper_low: raw_jumper_low_i,
                  start_wait: start_wait_i, password_set: password_set_i};
    end
  end

  // debounce
  logic btn_stable, jmp_stable;

  pcdt_debounce u_btn_deb (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (advance),
    .raw_i        (item_q.raw_button_low),
    .limit_i      (button_deb_q),
    .stable_next_o(btn_stable)
  );

  pcdt_debounce u_jmp_deb (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (advance),
    .raw_i        (item_q.raw_jumper_low),
    .limit_i      (jumper_deb_q),
    .stable_next_o(jmp_stable)
  );

  // wait logic
  wait_status_e        status_q, status_d;
  logic [TimeoutW-1:0] elapsed_q, elapsed_d, elapsed_base;
  logic                press_act_q, press_act_d, press_act_base;
  logic [HoldW-1:0]    press_el_q, press_el_d, press_el_base;
  logic                use_button, use_jumper, do_tick, first, ok;
  logic                now;

  assign use_button = (mode_q == ModeButton) || (mode_q == ModeEither);
  assign use_jumper = (mode_q == ModeJumper) || (mode_q == ModeEither);

  always_comb begin
    status_d       = status_q;
    elapsed_base   = elapsed_q;
    press_act_base = press_act_q;
    press_el_base  = press_el_q;
    do_tick        = 1'b0;
    first          = 1'b0;
    ok             = 1'b0;

    if (item_q.start_wait) begin
      if ((mode_q == ModeDisabled) || item_q.password_set) begin
        status_d = StNotRequired;
      end else begin
        status_d       = StWaiting;
        elapsed_base   = '0;
        press_act_base = 1'b0;
        press_el_base  = '0;
        do_tick        = 1'b1;
        first          = 1'b1;
      end
    end else if (status_q == StWaiting) begin
      do_tick = 1'b1;
    end

    elapsed_d   = elapsed_base;
    press_act_d = press_act_base;
    press_el_d  = press_el_base;

    if (do_tick) begin
      if (!first && !(&elapsed_base)) begin
        elapsed_d = elapsed_base + {{(TimeoutW-1){1'b0}}, 1'b1};
      end
      if (elapsed_d >= timeout_q) begin
        status_d = StTimeout;
      end else begin
        if (use_button && btn_stable) begin
          if (!press_act_base) begin
            press_act_d = 1'b1;
            press_el_d  = '0;
          end else begin
            if (!(&press_el_base)) begin
              press_el_d = press_el_base + {{(HoldW-1){1'b0}}, 1'b1};
            end
            ok = (press_el_d >= press_min_q);
          end
        end else begin
          press_act_d = 1'b0;
        end
        if (use_jumper && jmp_stable) begin
          ok = 1'b1;
        end
        if (ok) begin
          status_d = StConfirmed;
        end
      end
    end

    case (mode_q)
      ModeDisabled: now = 1'b1;
      ModeButton:   now = btn_stable;
      ModeJumper:   now = jmp_stable;
      default:      now = btn_stable | jmp_stable;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q    <= StIdle;
      elapsed_q   <= '0;
      press_act_q <= 1'b0;
      press_el_q  <= '0;
    end else if (advance) begin
      status_q    <= status_d;
      elapsed_q   <= elapsed_d;
      press_act_q <= press_act_d;
      press_el_q  <= press_el_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_free) begin
      out_valid_o <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      button_pressed_o   <= btn_stable;
      jumper_installed_o <= jmp_stable;
      confirmed_now_o    <= now;
      wait_status_o      <= status_d;
    end
  end

  // a stall is only raised with a full input stage
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("stall raised with empty input stage");

  // a finished status only changes on a new start
  a_status_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !item_q.start_wait && (status_q != StWaiting)) |=>
      (status_q == $past(status_q)))
    else $error("finished wait status changed without start");

  // a delivered result always matches the status register
  a_out_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (wait_status_o == status_q))
    else $error("result status differs from wait state");

  // disabled mode reports confirmation at once
  a_mode_off_now: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (mode_q == ModeDisabled)) |=> confirmed_now_o)
    else $error("disabled mode must report confirmed_now");

endmodule

### dv/pcdt_confirm_checker.sv
`timescale 1ns / 100ps
// Checker for physical_confirm_debounce_timeout_unit: follows the tick, result
// and register write channels, predicts every tick's result and compares it.
// Depends on pcdt_pkg.
module pcdt_confirm_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic                          raw_button_low_i,
  input  logic                          raw_jumper_low_i,
  input  logic                          start_wait_i,
  input  logic                          password_set_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic                          button_pressed_i,
  input  logic                          jumper_installed_i,
  input  logic                          confirmed_now_i,
  input  logic [2:0]                    wait_status_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [pcdt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pcdt_pkg::TimeoutW-1:0] cfg_data_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   outstanding_o
);
  import pcdt_pkg::*;

  typedef struct packed {
    logic             prev;
    logic             known;
    logic             stable;
    logic [HoldW-1:0] hold;
  } pin_filter_t;

  typedef struct packed {
    logic         pressed;
    logic         installed;
    logic         now;
    wait_status_e status;
  } tick_view_t;

  confirm_mode_e       mode_q;
  logic [HoldW-1:0]    btn_deb_q, jmp_deb_q, press_min_q;
  logic [TimeoutW-1:0] timeout_q;
  pin_filter_t         btn_q, jmp_q;
  logic [TimeoutW-1:0] elapsed_q;
  logic                press_on_q;
  logic [HoldW-1:0]    press_len_q;
  wait_status_e        status_q;
  tick_view_t          expected_views[$];
  int unsigned         fails = 0;

  assign fail_count_o = fails;

  task automatic report_failure(input string what);
    fails++;
    $display("%0t ERROR %s", $time, what);
  endtask

  function automatic pin_filter_t filter_pin(input pin_filter_t p, input logic raw,
                                             input logic [HoldW-1:0] limit);
    pin_filter_t n;
    n = p;
    if (!p.known || raw != p.prev) begin
      n.hold = '0;
    end else if (p.hold != '1) begin
      n.hold = p.hold + 1'b1;
    end
    if (n.hold >= limit) n.stable = raw;
    n.prev  = raw;
    n.known = 1'b1;
    return n;
  endfunction

  task automatic run_wait_tick(input logic first);
    logic by_button, by_jumper, ok;
    by_button = (mode_q == ModeButton) || (mode_q == ModeEither);
    by_jumper = (mode_q == ModeJumper) || (mode_q == ModeEither);
    ok = 1'b0;
    if (!first && elapsed_q != '1) elapsed_q = elapsed_q + 1'b1;
    if (elapsed_q >= timeout_q) begin
      status_q = StTimeout;
    end else begin
      if (by_button && btn_q.stable) begin
        if (!press_on_q) begin
          press_on_q  = 1'b1;
          press_len_q = '0;
        end else begin
          if (press_len_q != '1) press_len_q = press_len_q + 1'b1;
          if (press_len_q >= press_min_q) ok = 1'b1;
        end
      end else begin
        press_on_q = 1'b0;
      end
      if (by_jumper && jmp_q.stable) ok = 1'b1;
      if (ok) status_q = StConfirmed;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    tick_view_t want;
    if (!rst_ni) begin
      mode_q      = ModeEither;
      btn_deb_q   = ButtonDebReset;
      jmp_deb_q   = JumperDebReset;
      press_min_q = PressMinReset;
      timeout_q   = TimeoutReset;
      btn_q       = '0;
      jmp_q       = '0;
      elapsed_q   = '0;
      press_on_q  = 1'b0;
      press_len_q = '0;
      status_q    = StIdle;
      expected_views.delete();
    end else begin
      // result side first: a tick taken at this edge cannot leave at it
      if (out_valid_i && !out_stall_i) begin
        if (expected_views.size() == 0) begin
          report_failure("result transfer with no tick outstanding");
        end else begin
          want = expected_views.pop_front();
          if (button_pressed_i !== want.pressed)
            report_failure($sformatf("button_pressed got %b want %b",
                                     button_pressed_i, want.pressed));
          if (jumper_installed_i !== want.installed)
            report_failure($sformatf("jumper_installed got %b want %b",
                                     jumper_installed_i, want.installed));
          if (confirmed_now_i !== want.now)
            report_failure($sformatf("confirmed_now got %b want %b",
                                     confirmed_now_i, want.now));
          if (wait_status_i !== want.status)
            report_failure($sformatf("wait_status got %0d want %0d",
                                     wait_status_i, want.status));
        end
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgConfirmMode: mode_q      = confirm_mode_e'(cfg_data_i[ModeW-1:0]);
          CfgButtonDeb:   btn_deb_q   = cfg_data_i[HoldW-1:0];
          CfgJumperDeb:   jmp_deb_q   = cfg_data_i[HoldW-1:0];
          CfgPressMin:    press_min_q = cfg_data_i[HoldW-1:0];
          CfgWaitTimeout: timeout_q   = cfg_data_i;
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        btn_q = filter_pin(btn_q, raw_button_low_i, btn_deb_q);
        jmp_q = filter_pin(jmp_q, raw_jumper_low_i, jmp_deb_q);
        if (start_wait_i) begin
          if (mode_q == ModeDisabled || password_set_i) begin
            status_q = StNotRequired;
          end else begin
            status_q    = StWaiting;
            elapsed_q   = '0;
            press_on_q  = 1'b0;
            press_len_q = '0;
            run_wait_tick(1'b1);
          end
        end else if (status_q == StWaiting) begin
          run_wait_tick(1'b0);
        end
        want.pressed   = btn_q.stable;
        want.installed = jmp_q.stable;
        case (mode_q)
          ModeDisabled: want.now = 1'b1;
          ModeButton:   want.now = btn_q.stable;
          ModeJumper:   want.now = jmp_q.stable;
          default:      want.now = btn_q.stable | jmp_q.stable;
        endcase
        want.status = status_q;
        expected_views.push_back(want);
      end
    end
    outstanding_o <= expected_views.size();
  end

endmodule

### dv/tb_physical_confirm_debounce_timeout_unit.sv
`timescale 1ns / 100ps
// Testbench top for physical_confirm_debounce_timeout_unit: drives ticks and
// register writes with random gaps and stalls, gives the verdict.
// Depends on pcdt_pkg, the unit and pcdt_confirm_checker.
module tb_physical_confirm_debounce_timeout_unit;
  import pcdt_pkg::*;

  localparam int unsigned CycleLimit = 1000000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                raw_button_low = 1'b0;
  logic                raw_jumper_low = 1'b0;
  logic                start_wait = 1'b0;
  logic                password_set = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                button_pressed;
  logic                jumper_installed;
  logic                confirmed_now;
  logic [2:0]          wait_status;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [TimeoutW-1:0] cfg_data = '0;
  int unsigned         fail_count;
  int unsigned         outstanding;
  int unsigned         cycles = 0;
  logic                calm = 1'b0;
  int unsigned         stall_left = 0;
  logic                stall_on = 1'b0;

  physical_confirm_debounce_timeout_unit i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .raw_button_low_i   (raw_button_low),
    .raw_jumper_low_i   (raw_jumper_low),
    .start_wait_i       (start_wait),
    .password_set_i     (password_set),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .button_pressed_o   (button_pressed),
    .jumper_installed_o (jumper_installed),
    .confirmed_now_o    (confirmed_now),
    .wait_status_o      (wait_status),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data)
  );

  pcdt_confirm_checker i_confirm_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_i         (in_stall),
    .raw_button_low_i   (raw_button_low),
    .raw_jumper_low_i   (raw_jumper_low),
    .start_wait_i       (start_wait),
    .password_set_i     (password_set),
    .out_valid_i        (out_valid),
    .out_stall_i        (out_stall),
    .button_pressed_i   (button_pressed),
    .jumper_installed_i (jumper_installed),
    .confirmed_now_i    (confirmed_now),
    .wait_status_i      (wait_status),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_i        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .fail_count_o       (fail_count),
    .outstanding_o      (outstanding)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("physical_confirm_debounce_timeout_unit test failed");
    $finish;
  end

  function automatic int unsigned gap_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [TimeoutW-1:0] pick_value(input int unsigned hi,
                                                     input logic [TimeoutW-1:0] extreme);
    if ($urandom_range(0, 9) == 0) return extreme;
    return TimeoutW'($urandom_range(0, hi));
  endfunction

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_on   = !calm && ($urandom_range(0, 3) == 0);
      stall_left = stall_on ? gap_len() : $urandom_range(1, 8);
    end
    stall_left--;
    out_stall <= stall_on;
  end

  task automatic send_tick(input logic btn, input logic jmp, input logic start,
                           input logic pw);
    int unsigned gap;
    gap = (calm || $urandom_range(0, 2) != 0) ? 0 : gap_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid       <= 1'b1;
    raw_button_low <= btn;
    raw_jumper_low <= jmp;
    start_wait     <= start;
    password_set   <= pw;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [TimeoutW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
  endtask

  task automatic program_regs(input confirm_mode_e mode, input logic [HoldW-1:0] bdeb,
                              input logic [HoldW-1:0] jdeb, input logic [HoldW-1:0] pmin,
                              input logic [TimeoutW-1:0] tmo);
    logic [TimeoutW-1:0] noise;
    drain();
    // upper bits beyond each register's width carry junk
    noise = TimeoutW'($urandom);
    noise[ModeW-1:0] = mode;
    write_reg(CfgConfirmMode, noise);
    noise = TimeoutW'($urandom);
    noise[HoldW-1:0] = bdeb;
    write_reg(CfgButtonDeb, noise);
    noise = TimeoutW'($urandom);
    noise[HoldW-1:0] = jdeb;
    write_reg(CfgJumperDeb, noise);
    noise = TimeoutW'($urandom);
    noise[HoldW-1:0] = pmin;
    write_reg(CfgPressMin, noise);
    write_reg(CfgWaitTimeout, tmo);
    if ($urandom_range(0, 3) == 0)
      write_reg(CfgIdxW'($urandom_range(CfgWaitTimeout + 1, (1 << CfgIdxW) - 1)),
                TimeoutW'($urandom));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    confirm_mode_e       mode;
    logic [HoldW-1:0]    bdeb, jdeb, pmin;
    logic [TimeoutW-1:0] tmo;
    int unsigned         span, btn_run, jmp_run;
    logic                btn, jmp, start, pw;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults after reset, first sample with unknown history
    send_tick(1'b1, 1'b1, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b1, 1'b1);
    send_tick(1'b0, 1'b0, 1'b1, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0, 1'b0);

    // zero debounce, zero press, zero timeout
    program_regs(ModeEither, '0, '0, '0, '0);
    send_tick(1'b1, 1'b1, 1'b1, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0, 1'b0);

    // button press held to confirm, jumper ignored
    program_regs(ModeButton, 16'd1, 16'd0, 16'd2, 24'd12);
    send_tick(1'b0, 1'b1, 1'b1, 1'b0);
    repeat (5) send_tick(1'b1, 1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1, 1'b1);

    // jumper only: timeout with button held, then jumper confirm
    program_regs(ModeJumper, 16'd1, 16'd1, 16'd2, 24'd3);
    send_tick(1'b1, 1'b0, 1'b1, 1'b0);
    repeat (3) send_tick(1'b1, 1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b1, 1'b0);
    send_tick(1'b0, 1'b1, 1'b0, 1'b0);

    program_regs(ModeDisabled, 16'd1, 16'd1, 16'd2, 24'd3);
    send_tick(1'b0, 1'b0, 1'b1, 1'b0);

    // mode changes while a wait is open
    program_regs(ModeEither, '0, '0, 16'd3, 24'd20);
    send_tick(1'b1, 1'b0, 1'b1, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0, 1'b0);
    program_regs(ModeJumper, '0, '0, 16'd3, 24'd20);
    repeat (2) send_tick(1'b1, 1'b0, 1'b0, 1'b0);
    program_regs(ModeEither, '0, '0, 16'd3, 24'd20);
    repeat (2) send_tick(1'b1, 1'b0, 1'b0, 1'b0);
    program_regs(ModeDisabled, '0, '0, 16'd3, 24'd4);
    send_tick(1'b1, 1'b0, 1'b0, 1'b0);

    // longest debounce and longest press, run back to back
    calm = 1'b1;
    program_regs(ModeButton, '0, '0, '1, '1);
    repeat (2) send_tick(1'b0, 1'b0, 1'b0, 1'b0);
    program_regs(ModeButton, '0, '1, '1, '1);
    send_tick(1'b1, 1'b1, 1'b1, 1'b0);
    repeat (20) send_tick(1'b1, 1'b1, 1'b0, 1'b0);
    calm = 1'b0;

    for (int p = 0; p < 12; p++) begin
      mode = confirm_mode_e'($urandom_range(0, 3));
      bdeb = HoldW'(pick_value(4, '1));
      jdeb = HoldW'(pick_value(4, '1));
      pmin = HoldW'(pick_value(8, '1));
      tmo  = pick_value(40, '1);
      program_regs(mode, bdeb, jdeb, pmin, tmo);
      calm = ($urandom_range(0, 3) == 0);
      span = 4;
      span += (bdeb > 20) ? 20 : bdeb;
      span += (pmin > 20) ? 20 : pmin;
      btn = 1'b0;
      jmp = 1'b0;
      btn_run = 0;
      jmp_run = 0;
      for (int i = 0; i < 72; i++) begin
        if (btn_run == 0) begin
          btn = ~btn;
          btn_run = $urandom_range(1, span);
        end
        if (jmp_run == 0) begin
          jmp = ($urandom_range(0, 2) == 0);
          jmp_run = $urandom_range(1, span);
        end
        btn_run--;
        jmp_run--;
        start = (i == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 29) == 0);
        pw    = ($urandom_range(0, 5) == 0);
        if ($urandom_range(0, 59) == 0) drain();
        send_tick(btn ^ ($urandom_range(0, 11) == 0), jmp ^ ($urandom_range(0, 15) == 0),
                  start, pw);
      end
    end
    calm = 1'b0;

    drain();
    repeat (6) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("physical_confirm_debounce_timeout_unit test passed");
    end else begin
      $display("physical_confirm_debounce_timeout_unit test failed");
    end
    $finish;
  end

endmodule
